FILE: src/mdc_pkg.sv
// Shared types and constants for the map delta coordinate decoder.
// Used by mdc_cfg, mdc_core and map_delta_coord_decoder_top; no dependencies.
`timescale 1ns / 1ps

package mdc_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_BOX_LEFT   = 2'd0;
    localparam logic [1:0] CFG_BOX_TOP    = 2'd1;
    localparam logic [1:0] CFG_BOX_RIGHT  = 2'd2;
    localparam logic [1:0] CFG_BOX_BOTTOM = 2'd3;

    // Input command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // Field width in bytes per axis
    localparam logic [2:0] FB_2 = 3'd2;
    localparam logic [2:0] FB_3 = 3'd3;
    localparam logic [2:0] FB_4 = 3'd4;

    // Box span thresholds for width selection
    localparam logic signed [32:0] SPAN_3B = 33'sd32767;
    localparam logic signed [32:0] SPAN_4B = 33'sd8388608;

    // Field masks and sign-magnitude bias per width
    localparam logic [31:0] MASK_2B = 32'h0000_ffff;
    localparam logic [31:0] MASK_3B = 32'h00ff_ffff;
    localparam logic [31:0] MASK_4B = 32'hffff_ffff;
    localparam logic [31:0] BIAS_2B = 32'h0001_0000;
    localparam logic [31:0] BIAS_3B = 32'h0100_0000;
    localparam logic [31:0] BIAS_4B = 32'h0000_0000;

    // Run status values
    localparam logic [2:0] RS_STOPPED = 3'd4;
    localparam logic [2:0] RS_END     = 3'd5;
    localparam logic [2:0] RS_STEP    = 3'd2;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
        logic       start_status;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic               kind;
        logic               next_mark;
        logic               marker;
    } t_out_item;

    // Configuration view handed to the decode core
    typedef struct packed {
        logic [31:0] box_left;
        logic [31:0] box_bottom;
        logic [2:0]  field_bytes;
        logic        busy;
    } t_cfg_view;

endpackage

FILE: src/mdc_cfg.sv
// Bounding box registers and registered field-width selection.
// Depends on mdc_pkg.
`timescale 1ns / 1ps

module mdc_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output mdc_pkg::t_cfg_view   o_view
);
    import mdc_pkg::*;

    logic [31:0] r_left, r_top, r_right, r_bottom;
    logic [2:0]  r_fb, n_fb;
    logic        r_busy;
    logic signed [32:0] dx, dy;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_right  <= '0;
            r_bottom <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BOX_LEFT:   r_left   <= i_cfg_data;
                CFG_BOX_TOP:    r_top    <= i_cfg_data;
                CFG_BOX_RIGHT:  r_right  <= i_cfg_data;
                CFG_BOX_BOTTOM: r_bottom <= i_cfg_data;
            endcase
        end
    end

    // Exact box spans, no wrap
    assign dx = $signed({r_right[31], r_right}) - $signed({r_left[31], r_left});
    assign dy = $signed({r_top[31], r_top}) - $signed({r_bottom[31], r_bottom});

    always_comb begin
        n_fb = FB_2;
        if (dx > SPAN_3B || dy > SPAN_3B) n_fb = FB_3;
        if (dx > SPAN_4B || dy > SPAN_4B) n_fb = FB_4;
    end

    // Width is registered; busy is raised while it settles after a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb   <= FB_2;
            r_busy <= 1'b0;
        end else begin
            r_fb   <= n_fb;
            r_busy <= i_cfg_valid;
        end
    end

    assign o_view = '{box_left: r_left, box_bottom: r_bottom,
                      field_bytes: r_fb, busy: r_busy};

endmodule

FILE: src/mdc_core.sv
// Decode state (byte index, accumulators, run status) and one-item step logic.
// Depends on mdc_pkg.
`timescale 1ns / 1ps

module mdc_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  mdc_pkg::t_in_item    i_item,
    input  mdc_pkg::t_cfg_view   i_cfg,
    output logic                 o_res_valid,
    output mdc_pkg::t_out_item   o_res
);
    import mdc_pkg::*;

    logic [2:0]  r_idx, n_idx;
    logic [31:0] r_x, n_x, r_y, n_y;
    logic [2:0]  r_rs, n_rs;

    logic [2:0]  fb, j;
    logic [31:0] b32, mask, bias, xm, ym, mag;
    logic        is_x, done, mk, nxt, kind, run;
    logic [2:0]  rs_inc;

    always_comb begin
        fb   = i_cfg.field_bytes;
        b32  = {24'd0, i_item.data_byte};
        is_x = (r_idx < fb);
        j    = r_idx - fb;
        run  = (r_rs < RS_STOPPED);

        // Shift the byte into its accumulator
        n_x = r_x;
        n_y = r_y;
        if (is_x) begin
            if (r_idx == 3'd0) n_x = b32;
            else               n_x = r_x | (b32 << {r_idx[1:0], 3'b000});
        end else begin
            if (j == 3'd0)      n_y = b32;
            else if (j < 3'd4)  n_y = r_y | (b32 << {j[1:0], 3'b000});
        end

        // Point completes at byte 2n-1 or later
        done = ({1'b0, r_idx} + 4'd1) >= {fb, 1'b0};

        case (fb)
            FB_2:    begin mask = MASK_2B; bias = BIAS_2B; end
            FB_3:    begin mask = MASK_3B; bias = BIAS_3B; end
            default: begin mask = MASK_4B; bias = BIAS_4B; end
        endcase
        xm = n_x & mask;
        ym = n_y & mask;
        case (fb)
            FB_2:    mk = xm[15];
            FB_3:    mk = xm[23];
            default: mk = xm[31];
        endcase
        mag    = mk ? (bias - xm) : xm;
        rs_inc = r_rs + RS_STEP;
        nxt    = mk && (r_rs != 3'd0);
        kind   = mk && (rs_inc == RS_END);

        // Next state
        n_idx = r_idx;
        n_rs  = r_rs;
        o_res_valid = 1'b0;
        if (i_item.cmd == CMD_START) begin
            n_idx = 3'd0;
            n_x   = '0;
            n_y   = '0;
            n_rs  = {2'b00, i_item.start_status};
        end else if (!run) begin
            n_x = r_x;
            n_y = r_y;
        end else if (!done) begin
            n_idx = r_idx + 3'd1;
        end else begin
            n_idx = 3'd0;
            if (mk) n_rs = rs_inc;
            o_res_valid = 1'b1;
        end

        o_res.point_x   = i_cfg.box_left + mag;
        o_res.point_y   = i_cfg.box_bottom + ym;
        o_res.kind      = kind;
        o_res.next_mark = nxt;
        o_res.marker    = mk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_x   <= '0;
            r_y   <= '0;
            r_rs  <= RS_STOPPED;
        end else if (i_step) begin
            r_idx <= n_idx;
            r_x   <= n_x;
            r_y   <= n_y;
            r_rs  <= n_rs;
        end
    end

endmodule

FILE: src/map_delta_coord_decoder_top.sv
// Top level of the map delta coordinate decoder: input and result registers.
// Depends on mdc_pkg, mdc_cfg and mdc_core.
//
// Usage: coordinate bytes and start commands arrive at most one item per cycle on the
// i_in_valid / o_in_ready channel. A start command (cmd 0) loads the run
// status from start_status and clears the byte index and accumulators; it
// gives no result. Data bytes build an x then a y field of 2, 3 or 4 bytes
// each, the width following from the bounding box registers. The last byte of
// a point gives one result item on o_out_valid / i_out_ready.
// The last byte passes through the input register and then loads the result
// register. Throughput: one item per cycle while neither a receiver stall nor
// a configuration write holds the accumulate/decode step.
// A receiver stall holds the result register; the input register takes at
// most one more item, then o_in_ready drops.
// Configuration: i_cfg_valid / o_cfg_ready (always ready), index 0..3 for
// box_left, box_top, box_right, box_bottom. In the cycle after a write, the
// decode step waits while the width selection settles.
// Reset (synchronous, active low) clears all registers but the input and result
// data; the run status comes up stopped, so data bytes are ignored until the first start command.
`timescale 1ns / 1ps

module map_delta_coord_decoder_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  mdc_pkg::t_in_item    i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output mdc_pkg::t_out_item   o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data
);
    import mdc_pkg::*;

    t_cfg_view  cfg_view;
    t_in_item   r_in;
    logic       r_in_valid;
    t_out_item  r_out, res;
    logic       r_out_valid, res_valid, step;

    assign o_cfg_ready = 1'b1;

    mdc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_view      (cfg_view)
    );

    // Process the held item when the result register can take a result and cfg is not busy
    assign step       = r_in_valid && !cfg_view.busy && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    mdc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (r_in),
        .i_cfg       (cfg_view),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
